// ===== hdl/gse_pkg.sv =====
// ----------------------------------------------------------------------------
// gse_pkg
// Shared constants and types for the glyph shadow expander.
// ----------------------------------------------------------------------------
package gse_pkg;

  localparam int GLYPH_ROWS = 15;   // bitmap rows per glyph, 2..15
  localparam int NUM_COLS   = 12;   // narrowed columns, last one always blank
  localparam int IN_W       = 16;
  localparam int NIB_W      = 4;
  localparam int ROW_W      = NUM_COLS * NIB_W;
  localparam int IDX_W      = 4;

  localparam logic [NIB_W-1:0] NIB_EMPTY  = 4'd0;
  localparam logic [NIB_W-1:0] NIB_GLYPH  = 4'd2;
  localparam logic [NIB_W-1:0] NIB_SHADOW = 4'd11;

  // per-row context handed to the shading logic
  typedef struct packed {
    logic first;        // first row of a glyph: row above is ignored
    logic diag_armed;   // diagonal flag carried from the previous row
  } shade_ctl_t;

endpackage

// ===== hdl/gse_row_shade.sv =====
// ----------------------------------------------------------------------------
// gse_row_shade
// Column narrowing and shadow rule for one glyph row, plus the shadow-only
// row that follows the last glyph row.
// ----------------------------------------------------------------------------
module gse_row_shade
  import gse_pkg::*;
(
  input  logic [IN_W-1:0]  glyph_row_i,
  input  logic [ROW_W-1:0] above_row_i,
  input  shade_ctl_t       ctl_i,
  output logic [ROW_W-1:0] row_pixels_o,
  output logic             diag_armed_o,
  output logic [ROW_W-1:0] extra_pixels_o
);

  logic [IN_W-1:0]     swapped;
  logic [NUM_COLS-1:0] cols;
  logic [NUM_COLS-1:0] left_glyph;

  // undo the byte swap; source column a sits at bit 15-a
  assign swapped = {glyph_row_i[7:0], glyph_row_i[15:8]};

  // 15 source columns to 11, column pairs ORed
  assign cols[0]  = swapped[15];
  assign cols[1]  = swapped[14] | swapped[13];
  assign cols[2]  = swapped[12];
  assign cols[3]  = swapped[11];
  assign cols[4]  = swapped[10] | swapped[9];
  assign cols[5]  = swapped[8];
  assign cols[6]  = swapped[7] | swapped[6];
  assign cols[7]  = swapped[5];
  assign cols[8]  = swapped[4];
  assign cols[9]  = swapped[3] | swapped[2];
  assign cols[10] = swapped[1];
  assign cols[11] = 1'b0;

  assign left_glyph = {cols[NUM_COLS-2:0], 1'b0};

  // glyph row: diagonal flag ripples left to right across empty cells
  always_comb begin
    logic [NIB_W-1:0] above;
    logic [NIB_W-1:0] nib;
    logic             armed;
    armed        = ctl_i.diag_armed & ~ctl_i.first;
    row_pixels_o = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      above = above_row_i[c*NIB_W +: NIB_W];
      nib   = NIB_EMPTY;
      if (cols[c]) begin
        nib = NIB_GLYPH;
      end else begin
        if (left_glyph[c]) nib = NIB_SHADOW;
        if (!ctl_i.first) begin
          if (c != 0 && above == NIB_SHADOW && armed) nib = NIB_SHADOW;
          if (above != NIB_EMPTY && above != NIB_SHADOW) begin
            nib   = NIB_SHADOW;
            armed = 1'b1;
          end else begin
            armed = 1'b0;
          end
        end
      end
      row_pixels_o[c*NIB_W +: NIB_W] = nib;
    end
    diag_armed_o = armed;
  end

  // shadow-only row below the last glyph row
  always_comb begin
    logic [NUM_COLS-1:0] glyph_above;
    logic [NUM_COLS-1:0] flag;
    logic [NIB_W-1:0]    above;
    for (int c = 0; c < NUM_COLS; c++) begin
      above          = above_row_i[c*NIB_W +: NIB_W];
      glyph_above[c] = (above != NIB_EMPTY) && (above != NIB_SHADOW);
    end
    flag           = {glyph_above[NUM_COLS-2:0], 1'b0};
    extra_pixels_o = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      above = above_row_i[c*NIB_W +: NIB_W];
      if (glyph_above[c] || (above == NIB_SHADOW && flag[c])) begin
        extra_pixels_o[c*NIB_W +: NIB_W] = NIB_SHADOW;
      end
    end
  end

endmodule

// ===== hdl/glyph_shadow_expander.sv =====
// ----------------------------------------------------------------------------
// glyph_shadow_expander
// Turns byte-swapped 1-bit glyph bitmap rows into 12-nibble pixel rows with
// a drop shadow, and appends one shadow-only row after each glyph.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | per transaction
//  ---------+----------------------------------+--------------------------------
//  in       | in_valid_i / in_ready_o          | glyph_row_i, one bitmap row
//  out      | out_valid_o / out_ready_i        | row_pixels_o, row_index_o, last_o
//
//  One input transaction per cycle is taken into an input register while
//  in_ready_o is high; the shading logic runs between that register and the
//  output register. Each glyph gives GLYPH_ROWS + 1 output transactions:
//  after the last bitmap row the output register loads the shadow-only row
//  before it takes the next bitmap row.
//  Reset clears the valid flags, row counter, row-above register and the
//  diagonal flag. A stalled output holds its data; the input register still
//  takes one more transaction while the output waits.
// ----------------------------------------------------------------------------
module glyph_shadow_expander
  import gse_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [IN_W-1:0]  glyph_row_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ROW_W-1:0] row_pixels_o,
  output logic [IDX_W-1:0] row_index_o,
  output logic             last_o
);

  localparam logic [IDX_W-1:0] LastRow  = IDX_W'(GLYPH_ROWS - 1);
  localparam logic [IDX_W-1:0] ExtraIdx = IDX_W'(GLYPH_ROWS);

  // input stage
  logic            in_valid_q;
  logic [IN_W-1:0] in_row_q;

  // glyph state
  logic [ROW_W-1:0] prev_row_q;
  logic [IDX_W-1:0] row_count_q;
  logic             diag_q;
  logic             extra_pend_q;   // shadow-only row still owed

  // output stage
  logic             out_valid_q;
  logic [ROW_W-1:0] out_pixels_q;
  logic [IDX_W-1:0] out_index_q;
  logic             out_last_q;

  shade_ctl_t       ctl;
  logic [ROW_W-1:0] glyph_pixels;
  logic [ROW_W-1:0] extra_pixels;
  logic             diag_next;
  logic             out_load;
  logic             load_extra;
  logic             load_glyph;
  logic             is_last;

  assign ctl.first      = (row_count_q == '0);
  assign ctl.diag_armed = diag_q;

  gse_row_shade u_shade (
    .glyph_row_i    (in_row_q),
    .above_row_i    (prev_row_q),
    .ctl_i          (ctl),
    .row_pixels_o   (glyph_pixels),
    .diag_armed_o   (diag_next),
    .extra_pixels_o (extra_pixels)
  );

  // output register frees up when empty or being drained this cycle
  assign out_load   = !out_valid_q || out_ready_i;
  // the owed shadow row goes ahead of the next bitmap row
  assign load_extra = out_load && extra_pend_q;
  assign load_glyph = out_load && !extra_pend_q && in_valid_q;
  assign is_last    = (row_count_q >= LastRow);

  assign in_ready_o = !in_valid_q || load_glyph;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_row_q <= glyph_row_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_row_q   <= '0;
      row_count_q  <= '0;
      diag_q       <= 1'b0;
      extra_pend_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (load_extra) begin
        extra_pend_q <= 1'b0;
        out_valid_q  <= 1'b1;
      end else if (load_glyph) begin
        prev_row_q   <= glyph_pixels;
        out_valid_q  <= 1'b1;
        if (is_last) begin
          row_count_q  <= '0;
          diag_q       <= 1'b0;
          extra_pend_q <= 1'b1;
        end else begin
          row_count_q  <= row_count_q + 1'b1;
          diag_q       <= diag_next;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_extra) begin
      out_pixels_q <= extra_pixels;
      out_index_q  <= ExtraIdx;
      out_last_q   <= 1'b1;
    end else if (load_glyph) begin
      out_pixels_q <= glyph_pixels;
      out_index_q  <= row_count_q;
      out_last_q   <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_pixels_o = out_pixels_q;
  assign row_index_o  = out_index_q;
  assign last_o       = out_last_q;

endmodule
